FILE: src/igc_pkg.sv
// Package for the index gap clustering block: item, result and config types,
// widths and register index codes. No dependencies.
package igc_pkg;

  localparam int unsigned IndexWidth = 32;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned GapWidth   = 32;
  localparam int unsigned CfgIdxWidth  = 4;
  localparam int unsigned CfgDataWidth = 32;

  typedef logic [IndexWidth-1:0] index_t;
  typedef logic [CountWidth-1:0] count_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MAX_GAP  = 4'd0,
    CFG_MIN_SIZE = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    index_t hit_index;
    logic   last_hit;
  } igc_in_t;

  typedef struct packed {
    logic   found;
    index_t region_begin;
    index_t region_final;
  } igc_out_t;

  typedef struct packed {
    logic [GapWidth-1:0] max_gap;
    count_t              min_size;
  } igc_cfg_t;

  // One item handed from the input stage to the cluster tracker
  typedef struct packed {
    logic    fire;
    igc_in_t item;
  } igc_step_t;

  localparam count_t CountMax = {CountWidth{1'b1}};

endpackage

FILE: src/igc_cluster.sv
// Cluster tracker: holds the per-set cluster state and computes the set
// result combinationally for the item being stepped. Depends on igc_pkg.
module igc_cluster (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  igc_pkg::igc_cfg_t cfg_i,
  input  igc_pkg::igc_step_t step_i,
  output igc_pkg::igc_out_t result_o
);
  import igc_pkg::*;

  logic   in_set_q, in_set_d;
  index_t prev_q, prev_d;
  index_t run_first_q, run_first_d;
  count_t run_count_q, run_count_d;
  logic   any_q, any_d;
  index_t begin_q, begin_d;
  index_t final_q, final_d;

  index_t gap;
  logic   first_hit;
  logic   brk;
  logic   closed_ok;
  logic   last_ok;
  count_t cnt_base;

  always_comb begin
    first_hit = !in_set_q;
    gap       = step_i.item.hit_index - prev_q;
    brk       = in_set_q && (GapWidth'(gap) > cfg_i.max_gap);
    closed_ok = brk && (run_count_q > count_t'(1)) && (run_count_q > cfg_i.min_size);

    if (first_hit) begin
      any_d   = 1'b0;
      begin_d = '0;
      final_d = '0;
    end else begin
      any_d   = any_q | closed_ok;
      begin_d = (closed_ok && !any_q) ? run_first_q : begin_q;
      final_d = closed_ok ? prev_q : final_q;
    end

    // open a new cluster on the first hit or after a wide gap
    run_first_d = (first_hit || brk) ? step_i.item.hit_index : run_first_q;
    cnt_base    = (first_hit || brk) ? '0 : run_count_q;
    run_count_d = (cnt_base == CountMax) ? cnt_base : cnt_base + count_t'(1);
    prev_d      = step_i.item.hit_index;
    in_set_d    = !step_i.item.last_hit;

    last_ok = run_count_d > cfg_i.min_size;

    result_o.found = any_d | last_ok;
    if (any_d) begin
      result_o.region_begin = begin_d;
    end else if (last_ok) begin
      result_o.region_begin = run_first_d;
    end else begin
      result_o.region_begin = '0;
    end
    if (last_ok) begin
      result_o.region_final = step_i.item.hit_index;
    end else if (any_d) begin
      result_o.region_final = final_d;
    end else begin
      result_o.region_final = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_set_q    <= 1'b0;
      any_q       <= 1'b0;
      run_count_q <= '0;
    end else if (step_i.fire) begin
      in_set_q    <= in_set_d;
      any_q       <= any_d;
      run_count_q <= run_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.fire) begin
      prev_q      <= prev_d;
      run_first_q <= run_first_d;
      begin_q     <= begin_d;
      final_q     <= final_d;
    end
  end

  a_count_nonzero_in_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_set_q |-> run_count_q != '0
  ) else $error("cluster count is zero inside a set");

  a_last_closes_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && step_i.item.last_hit |=> !in_set_q
  ) else $error("set still open after its last item");

  a_mid_keeps_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    step_i.fire && !step_i.item.last_hit |=> in_set_q
  ) else $error("set not open after a non-final item");

endmodule

FILE: src/index_gap_clustering.sv
// Index gap clustering, top level: input register, config registers, output
// register and the cluster tracker. Depends on igc_pkg and igc_cluster.
//
// Usage:
//   in channel (in_valid_i/in_ready_o/in_item_i) takes one hit index per item,
//   ascending within a set; last_hit marks the final hit of a set.
//   out channel (out_valid_o/out_ready_i/out_item_o) gives one result per set,
//   on its last hit: found, first index of the first qualifying cluster and
//   last index of the last qualifying cluster (both zero when not found).
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) writes
//   max_gap (index 0) and min_size (index 1); always ready; write while idle.
// Timing:
//   one item per cycle sustained. An item sits in the input register, where
//   a subtract and compares fold it into the cluster state; the result of a
//   last hit is written to the output register as the hit leaves the input
//   register.
//   When the receiver stalls, non-final hits keep flowing; a final hit waits
//   in the input register until the output register is free.
// Reset: clears the tracker flags and count, both configs, both valids.
module index_gap_clustering (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  igc_pkg::igc_in_t                  in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output igc_pkg::igc_out_t                 out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [igc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [igc_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import igc_pkg::*;

  logic      s1_valid_q;
  igc_in_t   s1_item_q;
  logic      s1_go;
  igc_cfg_t  cfg_q;
  igc_step_t step;
  igc_out_t  result;
  logic      out_valid_q;
  igc_out_t  out_q;

  // a final hit advances only when the output register can take its result
  assign s1_go      = s1_valid_q && (!s1_item_q.last_hit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_GAP:  cfg_q.max_gap  <= cfg_data_i[GapWidth-1:0];
        CFG_MIN_SIZE: cfg_q.min_size <= cfg_data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  assign step.fire = s1_go;
  assign step.item = s1_item_q;

  igc_cluster u_cluster (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .step_i   (step),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_item_q.last_hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_item_q.last_hit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_not_found_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.region_begin == '0 && out_q.region_final == '0
  ) else $error("regions not zero on a result without a cluster");

  a_no_overwrite: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q)
  ) else $error("pending result overwritten or dropped");

  a_mid_hit_flows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_item_q.last_hit |-> in_ready_o
  ) else $error("non-final item stalled the input");

endmodule
